// ----- hdl/motor_command_framer_watchdog_assert.svh -----
// assertion macros shared by the checker files
// every macro assumes a clock named i_clk and an active low reset named i_rst_n
`ifndef MOTOR_COMMAND_FRAMER_WATCHDOG_ASSERT_SVH
`define MOTOR_COMMAND_FRAMER_WATCHDOG_ASSERT_SVH

// same-cycle implication
`define MCFW_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define MCFW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- hdl/mcfw_pkg.sv -----
package mcfw_pkg;

    localparam int FRAME_LEN = 11;
    localparam int IDX_W     = $clog2(FRAME_LEN);
    localparam int SPEED_W   = 25;
    localparam int MAG_W     = 24;
    localparam int CNT_W     = 16;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0]       SYNC_BYTE   = 8'hFF;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd150;

    // one frame waiting to be sent
    typedef struct packed {
        logic             stop;
        logic             l_sign;
        logic [MAG_W-1:0] l_mag;
        logic             r_sign;
        logic [MAG_W-1:0] r_mag;
        logic [7:0]       csum;
    } t_frame;

    // frame queue status
    typedef struct packed {
        logic full;
        logic avail;
    } t_q_stat;

endpackage

// ----- hdl/mcfw_front.sv -----
module mcfw_front
    import mcfw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_cmd,
    input  logic signed [SPEED_W-1:0] i_left_speed,
    input  logic signed [SPEED_W-1:0] i_right_speed,
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_wdata,
    input  t_q_stat                   i_q_stat,
    output logic                      o_q_wr,
    output t_frame                    o_q_data
);

    typedef enum logic {
        CMD_SPEED = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    logic             r_pending, n_pending;
    logic [CNT_W-1:0] r_idle, n_idle;
    logic [CNT_W-1:0] r_limit;
    logic             r_l_sign, r_r_sign;
    logic [MAG_W-1:0] r_l_mag, r_r_mag;

    logic             w_accept, w_tick, w_speed, w_fire;
    logic [SPEED_W-1:0] w_l_neg, w_r_neg;
    logic             w_l_sign, w_r_sign;
    logic [MAG_W-1:0] w_l_mag, w_r_mag;
    t_frame           w_frame;

    function automatic logic [7:0] f_csum(logic ls, logic [MAG_W-1:0] lm,
                                          logic rs, logic [MAG_W-1:0] rm);
        logic [7:0] s;
        s = SYNC_BYTE + SYNC_BYTE + {7'd0, ls} + lm[23:16] + lm[15:8] + lm[7:0]
            + {7'd0, rs} + rm[23:16] + rm[15:8] + rm[7:0];
        return s;
    endfunction

    assign full     = i_q_stat.full;
    assign w_accept = push & ~i_q_stat.full;
    assign w_tick   = w_accept & (t_cmd'(i_cmd) == CMD_TICK);
    assign w_speed  = w_accept & (t_cmd'(i_cmd) == CMD_SPEED);
    assign w_fire   = w_tick & (r_pending | (r_idle == r_limit));

    // sign byte is 1 for positive or zero, magnitude keeps the low 24 bits
    assign w_l_neg  = ~i_left_speed + SPEED_W'(1);
    assign w_r_neg  = ~i_right_speed + SPEED_W'(1);
    assign w_l_sign = ~i_left_speed[SPEED_W-1];
    assign w_r_sign = ~i_right_speed[SPEED_W-1];
    assign w_l_mag  = w_l_sign ? i_left_speed[MAG_W-1:0] : w_l_neg[MAG_W-1:0];
    assign w_r_mag  = w_r_sign ? i_right_speed[MAG_W-1:0] : w_r_neg[MAG_W-1:0];

    always_comb begin
        if (r_pending) begin
            w_frame.stop   = 1'b0;
            w_frame.l_sign = r_l_sign;
            w_frame.l_mag  = r_l_mag;
            w_frame.r_sign = r_r_sign;
            w_frame.r_mag  = r_r_mag;
        end else begin
            w_frame.stop   = 1'b1;
            w_frame.l_sign = 1'b1;
            w_frame.l_mag  = '0;
            w_frame.r_sign = 1'b1;
            w_frame.r_mag  = '0;
        end
        w_frame.csum = f_csum(w_frame.l_sign, w_frame.l_mag, w_frame.r_sign, w_frame.r_mag);
    end

    assign o_q_wr   = w_fire;
    assign o_q_data = w_frame;

    always_comb begin
        n_pending = r_pending;
        n_idle    = r_idle;
        if (w_speed) begin
            n_pending = 1'b1;
        end
        if (w_tick) begin
            n_pending = 1'b0;
            n_idle    = (w_fire ? '0 : r_idle) + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_idle    <= '0;
            r_limit   <= LIMIT_RESET;
        end else begin
            r_pending <= n_pending;
            r_idle    <= n_idle;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // latched speeds, only read while pending
    always_ff @(posedge i_clk) begin
        if (w_speed && !r_pending) begin
            r_l_sign <= w_l_sign;
            r_l_mag  <= w_l_mag;
            r_r_sign <= w_r_sign;
            r_r_mag  <= w_r_mag;
        end
    end

endmodule

// ----- hdl/mcfw_fifo.sv -----
module mcfw_fifo
    import mcfw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_frame  i_wdata,
    input  logic    i_rd,
    output t_q_stat o_stat,
    output t_frame  o_rdata
);

    t_frame            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_wr, w_rd;

    function automatic logic [QPTR_W-1:0] f_inc(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.avail = (r_cnt != '0);
    assign o_rdata      = r_mem[r_rd_ptr];
    assign w_wr         = i_wr & ~o_stat.full;
    assign w_rd         = i_rd & o_stat.avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= f_inc(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= f_inc(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// ----- hdl/mcfw_back.sv -----
module mcfw_back
    import mcfw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_frame     i_q_data,
    output logic       o_q_rd,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte,
    output logic       o_is_stop
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    t_frame           r_frame;
    logic             w_last, w_take;

    assign w_last = (r_idx == LAST_IDX);
    assign w_take = ~r_busy | (pop & w_last);
    assign o_q_rd = w_take & i_q_stat.avail;

    assign empty       = ~r_busy;
    assign o_last_byte = w_last;
    assign o_is_stop   = r_frame.stop;

    always_comb begin
        case (r_idx)
            IDX_W'(0): o_out_byte = SYNC_BYTE;
            IDX_W'(1): o_out_byte = SYNC_BYTE;
            IDX_W'(2): o_out_byte = {7'd0, r_frame.l_sign};
            IDX_W'(3): o_out_byte = r_frame.l_mag[23:16];
            IDX_W'(4): o_out_byte = r_frame.l_mag[15:8];
            IDX_W'(5): o_out_byte = r_frame.l_mag[7:0];
            IDX_W'(6): o_out_byte = {7'd0, r_frame.r_sign};
            IDX_W'(7): o_out_byte = r_frame.r_mag[23:16];
            IDX_W'(8): o_out_byte = r_frame.r_mag[15:8];
            IDX_W'(9): o_out_byte = r_frame.r_mag[7:0];
            IDX_W'(10): o_out_byte = r_frame.csum;
            default: o_out_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_take) begin
            r_busy <= i_q_stat.avail;
            r_idx  <= '0;
        end else if (pop) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_frame <= i_q_data;
        end
    end

endmodule

// ----- hdl/motor_command_framer_watchdog.sv -----
// a frame fired by a tick is queued and loaded into the serializer before it shows
// throughput: one item per cycle unless full; frames leave at one byte per cycle on pop
// the input side backs up only when both frame queue slots and the serializer are in use
// reset: synchronous active low; clears pending, idle counter, frame queue and serializer,
// and sets watchdog_limit back to 150
module motor_command_framer_watchdog
    import mcfw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // item side: taken when push is high and full is low
    input  logic                      push,
    output logic                      full,
    input  logic                      i_cmd,
    input  logic signed [SPEED_W-1:0] i_left_speed,
    input  logic signed [SPEED_W-1:0] i_right_speed,
    // result side: oldest byte shown while empty is low, taken on pop
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_byte,
    output logic                      o_is_stop,
    // watchdog_limit write port
    input  logic                      i_cfg_we,
    input  logic [CNT_W-1:0]          i_cfg_wdata
);

    // front to queue
    logic    w_q_wr;
    t_frame  w_q_wdata;
    // queue to back
    logic    w_q_rd;
    t_frame  w_q_rdata;
    t_q_stat w_q_stat;

    // front: classifies items, keeps pending speeds and the idle counter,
    // and decides which frame (if any) a tick sends
    mcfw_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_left_speed  (i_left_speed),
        .i_right_speed (i_right_speed),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_stat      (w_q_stat),
        .o_q_wr        (w_q_wr),
        .o_q_data      (w_q_wdata)
    );

    // two-entry queue of frame descriptors, checksum already computed
    mcfw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_q_wdata),
        .i_rd    (w_q_rd),
        .o_stat  (w_q_stat),
        .o_rdata (w_q_rdata)
    );

    // back: holds one frame and walks its 11 bytes, reloading right after
    // the checksum byte is popped so frames go out without a gap
    mcfw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (w_q_stat),
        .i_q_data    (w_q_rdata),
        .o_q_rd      (w_q_rd),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte),
        .o_is_stop   (o_is_stop)
    );

endmodule

// ----- hdl/mcfw_chk.sv -----
`include "motor_command_framer_watchdog_assert.svh"

module mcfw_chk
    import mcfw_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic [7:0]                o_out_byte,
    input logic                      o_last_byte,
    input logic                      o_is_stop
);

    // a waiting byte holds until taken
    `MCFW_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_out_byte) && $stable(o_last_byte))

    // bytes of a frame follow one another with no gap
    `MCFW_ASSERT_NEXT(a_no_gap, !empty && pop && !o_last_byte, !empty)

    // stop marking is the same on every byte of a frame
    `MCFW_ASSERT_NEXT(a_stop_kept, !empty && pop && !o_last_byte, $stable(o_is_stop))

    // the stop frame checksum is zero
    `MCFW_ASSERT_IMPL(a_stop_csum, !empty && o_is_stop && o_last_byte, o_out_byte == 8'h00)

endmodule

bind motor_command_framer_watchdog mcfw_chk u_chk (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import mcfw_pkg::*;

    // item kinds on i_cmd
    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // speed corner values, 25-bit two's complement
    localparam logic [SPEED_W-1:0] SPEED_MAX      = 25'h0FFFFFF;  // +16777215
    localparam logic [SPEED_W-1:0] SPEED_MIN      = 25'h1000001;  // -16777215
    localparam logic [SPEED_W-1:0] SPEED_MOST_NEG = 25'h1000000;  // -16777216, magnitude wraps
    localparam logic [SPEED_W-1:0] SPEED_NEG_ONE  = 25'h1FFFFFF;

    // cycles with no item moving on either side before the run is called hung
    localparam int STUCK_LIMIT = 2000;
    // settle time after the last byte, covers a tick still in flight with no frame
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    // one byte of a frame as it should leave the block
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       stop;
    } frame_byte_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_cmd;
    logic [SPEED_W-1:0] i_left_speed;
    logic [SPEED_W-1:0] i_right_speed;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         o_out_byte;
    logic               o_last_byte;
    logic               o_is_stop;
    logic               i_cfg_we;
    logic [CNT_W-1:0]   i_cfg_wdata;

    // framer state as the testbench sees it
    logic               mdl_pending;
    logic               mdl_left_sign;
    logic [MAG_W-1:0]   mdl_left_mag;
    logic               mdl_right_sign;
    logic [MAG_W-1:0]   mdl_right_mag;
    logic [CNT_W-1:0]   mdl_idle;
    logic [CNT_W-1:0]   mdl_limit;

    // bytes owed by the block, oldest first
    frame_byte_t        bytes_due[$];

    int                 fail_count    = 0;
    int                 send_idle_pct = 0;
    int                 pop_stall_pct = 0;
    logic               hold_off      = 1'b0;
    int                 stuck_cycles  = 0;

    motor_command_framer_watchdog dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_left_speed  (i_left_speed),
        .i_right_speed (i_right_speed),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .o_is_stop     (o_is_stop),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // framer prediction
    // ---------------------------------------------------------------

    // sign byte is 1 for zero or positive; the most negative speed keeps only
    // the low 24 bits of its magnitude, so it goes out as sign 0 magnitude 0
    task automatic to_sign_magnitude(input logic [SPEED_W-1:0] raw, output logic sgn,
                                     output logic [MAG_W-1:0] mag);
        logic [SPEED_W-1:0] negated;
        negated = -raw;
        if (raw[SPEED_W-1]) begin
            sgn = 1'b0;
            mag = negated[MAG_W-1:0];
        end else begin
            sgn = 1'b1;
            mag = raw[MAG_W-1:0];
        end
    endtask

    // lays out one 11-byte frame and queues every byte of it
    task automatic queue_frame(input logic stop, input logic ls, input logic [MAG_W-1:0] lm,
                               input logic rs, input logic [MAG_W-1:0] rm);
        logic [7:0]  b [FRAME_LEN];
        logic [7:0]  sum;
        frame_byte_t fb;
        b[0]  = SYNC_BYTE;
        b[1]  = SYNC_BYTE;
        b[2]  = {7'd0, ls};
        b[3]  = lm[23:16];
        b[4]  = lm[15:8];
        b[5]  = lm[7:0];
        b[6]  = {7'd0, rs};
        b[7]  = rm[23:16];
        b[8]  = rm[15:8];
        b[9]  = rm[7:0];
        sum   = 8'd0;
        for (int k = 0; k < FRAME_LEN - 1; k++)
            sum = sum + b[k];
        b[FRAME_LEN-1] = sum;
        for (int k = 0; k < FRAME_LEN; k++) begin
            fb.value = b[k];
            fb.last  = (k == FRAME_LEN - 1);
            fb.stop  = stop;
            bytes_due.push_back(fb);
        end
    endtask

    // advances the framer state by one accepted item
    task automatic advance_framer(input logic kind, input logic [SPEED_W-1:0] left,
                                  input logic [SPEED_W-1:0] right);
        if (kind == KIND_SPEED) begin
            // a command is latched only when no frame is waiting, else dropped
            if (!mdl_pending) begin
                to_sign_magnitude(left, mdl_left_sign, mdl_left_mag);
                to_sign_magnitude(right, mdl_right_sign, mdl_right_mag);
                mdl_pending = 1'b1;
            end
        end else begin
            if (mdl_pending) begin
                queue_frame(1'b0, mdl_left_sign, mdl_left_mag, mdl_right_sign, mdl_right_mag);
                mdl_pending = 1'b0;
                mdl_idle    = '0;
            end else if (mdl_idle == mdl_limit) begin
                // watchdog stop frame: both wheels positive, zero speed
                queue_frame(1'b1, 1'b1, '0, 1'b1, '0);
                mdl_idle = '0;
            end
            // 16-bit counter, wraps from 65535 to 0
            mdl_idle = mdl_idle + 1'b1;
        end
    endtask

    task automatic reset_framer_model();
        mdl_pending    = 1'b0;
        mdl_left_sign  = 1'b0;
        mdl_left_mag   = '0;
        mdl_right_sign = 1'b0;
        mdl_right_mag  = '0;
        mdl_idle       = '0;
        mdl_limit      = LIMIT_RESET;
    endtask

    // ---------------------------------------------------------------
    // result side: pop pattern, byte checking and hang watchdog
    // ---------------------------------------------------------------

    // random stalls, or a solid hold-off while the input side is pressed
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // compares every byte taken with the oldest one owed
    always @(posedge i_clk) begin
        frame_byte_t want;
        if (i_rst_n && pop && !empty) begin
            if (bytes_due.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b stop %0b at %0t",
                             o_out_byte, o_last_byte, o_is_stop, $realtime);
            end else begin
                want = bytes_due.pop_front();
                if (o_out_byte !== want.value || o_last_byte !== want.last
                        || o_is_stop !== want.stop) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("byte mismatch at %0t: expected %02h/%0b/%0b got %02h/%0b/%0b",
                                 $realtime, want.value, want.last, want.stop,
                                 o_out_byte, o_last_byte, o_is_stop);
                end
            end
        end
    end

    // no item moving on either side for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // shared drivers; each starts just after a rising edge
    // ---------------------------------------------------------------

    // offers one item, holds it until taken, then predicts its bytes
    task automatic send_item(input logic kind, input logic [SPEED_W-1:0] left,
                             input logic [SPEED_W-1:0] right);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_cmd         <= kind;
        i_left_speed  <= left;
        i_right_speed <= right;
        do
            @(posedge i_clk);
        while (full);
        advance_framer(kind, left, right);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, random_speed(), random_speed());
    endtask

    // waits out every owed byte, then a little more for a frameless tick
    task automatic drain();
        push <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the block drained
    task automatic write_limit(input logic [CNT_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mdl_limit    = value;
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        pop_stall_pct <= stall_pct;
    endtask

    // mix of wide random, small values and the corners
    function automatic logic [SPEED_W-1:0] random_speed();
        int v;
        case ($urandom_range(3))
            1: begin
                v = $urandom_range(600);
                v = v - 300;
                return v[SPEED_W-1:0];
            end
            2: begin
                case ($urandom_range(3))
                    0: return SPEED_MAX;
                    1: return SPEED_MIN;
                    2: return SPEED_MOST_NEG;
                    default: return '0;
                endcase
            end
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // limit after reset is 150: the 151st idle tick brings the stop frame
    task automatic test_reset_limit();
        repeat (int'(LIMIT_RESET) + 1) send_tick();
        drain();
    endtask

    // frame layout, sign handling, dropped commands, ignored tick fields
    task automatic test_frame_contents();
        send_tick();
        send_item(KIND_SPEED, '0, '0);
        send_item(KIND_TICK, '0, '0);
        send_item(KIND_SPEED, SPEED_MAX, SPEED_MIN);
        // dropped: a frame is already waiting
        send_item(KIND_SPEED, 25'd5, SPEED_NEG_ONE);
        send_item(KIND_TICK, SPEED_MAX, SPEED_MOST_NEG);
        send_item(KIND_SPEED, SPEED_MOST_NEG, SPEED_NEG_ONE);
        send_item(KIND_TICK, '0, '0);
        send_item(KIND_SPEED, 25'd1, SPEED_MOST_NEG);
        send_item(KIND_TICK, SPEED_NEG_ONE, SPEED_NEG_ONE);
        send_item(KIND_SPEED, 25'h0ABCDEF & 25'h0FFFFFF, 25'h1543210);
        send_item(KIND_SPEED, SPEED_MIN, SPEED_MAX);
        send_tick();
        send_tick();
        send_item(KIND_SPEED, 25'h1555555, 25'h0AAAAAA);
        send_tick();
        drain();
    endtask

    // limit of one: every idle tick sends a stop frame
    task automatic test_limit_one();
        write_limit(16'd1);
        send_tick();
        send_tick();
        send_tick();
        send_item(KIND_SPEED, 25'd300, SPEED_MIN);
        send_tick();
        send_tick();
        drain();
    endtask

    // receiver holds off long enough for the frame queue to fill and push back
    task automatic test_input_stall();
        set_idling(0, 0);
        write_limit(16'd1);
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            begin
                for (int k = 0; k < 10; k++) begin
                    if (k % 3 == 1)
                        send_item(KIND_SPEED, random_speed(), random_speed());
                    send_tick();
                end
            end
        join
        drain();
    endtask

    // mostly command then tick with random content, plus noise
    task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                       input logic [CNT_W-1:0] limit, input int n_items);
        int sent;
        sent = 0;
        set_idling(send_pct, stall_pct);
        write_limit(limit);
        while (sent < n_items) begin
            case ($urandom_range(9))
                7: begin
                    send_tick();
                    sent = sent + 1;
                end
                8: begin
                    send_item(KIND_SPEED, random_speed(), random_speed());
                    sent = sent + 1;
                end
                9: begin
                    send_tick();
                    send_tick();
                    sent = sent + 2;
                end
                default: begin
                    send_item(KIND_SPEED, random_speed(), random_speed());
                    // now and then a second command that should be dropped
                    if ($urandom_range(4) == 0) begin
                        send_item(KIND_SPEED, random_speed(), random_speed());
                        sent = sent + 1;
                    end
                    send_tick();
                    sent = sent + 2;
                end
            endcase
        end
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_cmd         <= KIND_SPEED;
        i_left_speed  <= '0;
        i_right_speed <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        reset_framer_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_limit();
        test_frame_contents();
        test_limit_one();
        test_input_stall();
        test_random_traffic(0, 0, 16'($urandom_range(1, 4)), 8);
        test_random_traffic(87, 0, 16'($urandom_range(1, 8)), 8);
        test_random_traffic(0, 87, 16'($urandom_range(2, 30)), 8);
        test_random_traffic(25, 25, 16'($urandom_range(1, 6)), 8);

        // any byte left owed counts as a failure
        if (bytes_due.size() != 0)
            fail_count = fail_count + 1;
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
